// ===== hdl/cbm_pkg.sv =====
// Package: shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_RESET = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [1:0] KIND_PRG    = 2'd0;
    localparam logic [1:0] KIND_CHR    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Job opcodes passed from the front part to the back part
    typedef enum logic [1:0] {
        JOB_STATUS  = 2'd0,
        JOB_BANKSET = 2'd1,
        JOB_REFRESH = 2'd2
    } job_op_t;

    // Snapshot of the state one item needs to produce its updates
    typedef struct packed {
        job_op_t    op;
        logic       do_prg;     // refresh program banks
        logic       do_chr;     // refresh character banks
        logic [7:0] sel;        // command value that picks slots
        logic [7:0] cmd_old;    // command value used inside bank adjust
        logic [3:0] one_code;   // single bank code for a 0x8001 write
        logic [7:0] one_val;
        logic [63:0] banks;     // bank_regs[7:0]
        logic [31:0] outer;     // outer_regs[3:0]
        logic       irq;
        logic [1:0] mir;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

// ===== hdl/cbm_ram.sv =====
// Generic single-port-write, registered-read RAM used as the job queue.
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/cbm_front.sv =====
// Front part: holds mapper state, applies each beat and issues a job.
module cbm_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           four_screen,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     cmd,
    input  logic [15:0]    address,
    input  logic [7:0]     write_data,
    input  logic [8:0]     scanline,
    input  logic           display_on,
    output logic           job_valid,
    input  logic           job_ready,
    output cbm_pkg::job_t  job
);
    logic [7:0] command_reg, command_next;
    logic [7:0] bank_reg [8];
    logic [7:0] bank_next [8];
    logic [7:0] outer_reg [4];
    logic [7:0] outer_next [4];
    logic       mirror_reg, mirror_next;
    logic [7:0] counter_reg, counter_next;
    logic [7:0] latch_reg, latch_next;
    logic       reload_reg, reload_next;
    logic       enable_reg, enable_next;
    logic       pending_reg, pending_next;
    logic [7:0] cnt_tmp;
    cbm_pkg::job_t job_c;
    logic       take;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign take      = in_valid && job_ready;

    // Next state and job for the item on the input
    always_comb begin
        command_next = command_reg;
        bank_next    = bank_reg;
        outer_next   = outer_reg;
        mirror_next  = mirror_reg;
        counter_next = counter_reg;
        latch_next   = latch_reg;
        reload_next  = reload_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        cnt_tmp      = counter_reg;
        job_c          = '0;
        job_c.op       = cbm_pkg::JOB_STATUS;
        job_c.sel      = command_reg;
        job_c.cmd_old  = command_reg;
        unique case (cbm_pkg::cmd_t'(cmd))
            cbm_pkg::CMD_WRITE: begin
                if (address[15]) begin
                    unique case ({address[14:13], address[0]})
                        3'b000: begin
                            job_c.op     = cbm_pkg::JOB_REFRESH;
                            job_c.sel    = write_data;
                            job_c.do_prg = write_data[6] != command_reg[6];
                            job_c.do_chr = write_data[7] != command_reg[7];
                            command_next = write_data;
                        end
                        3'b001: begin
                            bank_next[command_reg[2:0]] = write_data;
                            job_c.op       = cbm_pkg::JOB_BANKSET;
                            job_c.one_code = {1'b0, command_reg[2:0]};
                            job_c.one_val  = write_data;
                        end
                        3'b010: mirror_next = write_data[0];
                        3'b011: ;
                        3'b100: begin
                            reload_next  = 1'b0;
                            counter_next = write_data;
                        end
                        3'b101: begin
                            reload_next = 1'b0;
                            latch_next  = write_data;
                        end
                        3'b110: begin
                            reload_next  = 1'b0;
                            enable_next  = 1'b0;
                            pending_next = 1'b0;
                        end
                        default: begin
                            reload_next = 1'b0;
                            enable_next = 1'b1;
                        end
                    endcase
                end else if (address[14:13] == 2'b11) begin
                    if (!(outer_reg[3][7] && !outer_reg[3][4])) begin
                        outer_next[address[1:0]] = write_data;
                        job_c.op     = cbm_pkg::JOB_REFRESH;
                        job_c.do_prg = 1'b1;
                        job_c.do_chr = 1'b1;
                    end
                end
            end
            cbm_pkg::CMD_TICK: begin
                if (scanline <= 9'd239 && display_on && enable_reg && !reload_reg) begin
                    if (scanline == 9'd0 && cnt_tmp != 8'd0) begin
                        cnt_tmp = cnt_tmp - 8'd1;
                    end
                    if (cnt_tmp == 8'd0) begin
                        reload_next  = 1'b1;
                        cnt_tmp      = latch_reg;
                        pending_next = 1'b1;
                    end
                    counter_next = cnt_tmp - 8'd1;
                end
            end
            cbm_pkg::CMD_RESET: begin
                command_next = '0;
                bank_next    = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
                outer_next   = '{default: 8'd0};
                mirror_next  = 1'b0;
                counter_next = '0;
                latch_next   = '0;
                reload_next  = 1'b0;
                enable_next  = 1'b0;
                pending_next = 1'b0;
                job_c.op      = cbm_pkg::JOB_REFRESH;
                job_c.do_prg  = 1'b1;
                job_c.do_chr  = 1'b1;
                job_c.sel     = '0;
                job_c.cmd_old = '0;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++) begin
            job_c.banks[i*8 +: 8] = bank_next[i];
        end
        for (int i = 0; i < 4; i++) begin
            job_c.outer[i*8 +: 8] = outer_next[i];
        end
        job_c.irq = pending_next;
        job_c.mir = four_screen ? 2'd2 : {1'b0, mirror_next};
    end

    assign job = job_c;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg <= '0;
            bank_reg    <= '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
            outer_reg   <= '{default: 8'd0};
            mirror_reg  <= 1'b0;
            counter_reg <= '0;
            latch_reg   <= '0;
            reload_reg  <= 1'b0;
            enable_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end else if (take) begin
            command_reg <= command_next;
            bank_reg    <= bank_next;
            outer_reg   <= outer_next;
            mirror_reg  <= mirror_next;
            counter_reg <= counter_next;
            latch_reg   <= latch_next;
            reload_reg  <= reload_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
        end
    end

`ifndef SYNTHESIS
    a_reload_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(reload_reg) |-> pending_reg)
        else $error("reload set without pending irq");
    a_hold_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(take) |-> $stable(command_reg))
        else $error("command changed without a beat");
    a_ready_follows: assert property (@(posedge aclk) in_ready == job_ready)
        else $error("ready mismatch");
`endif
endmodule

// ===== hdl/cbm_back.sv =====
// Back part: walks a job and emits bank updates, then the status beat.
module cbm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  cbm_pkg::job_t job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_kind,
    output logic [2:0]    m_slot,
    output logic [11:0]   m_bank,
    output logic          m_irq_line,
    output logic [1:0]    m_mirroring,
    output logic          m_last
);
    // step 0..3 program, 4..11 character, 12 status
    logic [3:0]  step_reg, step_next;
    logic        emit;
    logic        is_last;
    logic        fire;
    logic [7:0]  o0, o1, o2, o3, cmdo, sel;
    logic [7:0]  bk [8];
    logic [15:0] pa;
    logic [7:0]  pv;
    logic [7:0]  pmask, pbase4;
    logic [3:0]  pbase;
    logic [11:0] pbank;
    logic [3:0]  emask;
    logic [12:0] ca, rel;
    logic [7:0]  cv, cmask, chi, cbank;
    logic [2:0]  cslot;
    logic [3:0]  code;
    logic [1:0]  kind_c;
    logic [2:0]  slot_c;
    logic [11:0] bank_c;

    always_comb begin
        for (int i = 0; i < 8; i++) bk[i] = job.banks[i*8 +: 8];
        o0 = job.outer[7:0];
        o1 = job.outer[15:8];
        o2 = job.outer[23:16];
        o3 = job.outer[31:24];
        cmdo = job.cmd_old;
        sel  = job.sel;
    end

    // Which code to work on at this step and whether it emits
    always_comb begin
        code = step_reg;
        emit = 1'b1;
        unique case (job.op)
            cbm_pkg::JOB_BANKSET: begin
                priority if (step_reg == 4'd12) begin
                    code = 4'd12;
                end else if (job.one_code == 4'd6 || job.one_code == 4'd7) begin
                    code = (job.one_code == 4'd6) ? 4'd0 : 4'd2;
                    emit = step_reg == 4'd0;
                end else if (job.one_code <= 4'd1) begin
                    code = 4'd4 + {1'b0, job.one_code[1:0], 1'b0} + {3'd0, step_reg[0]};
                    emit = step_reg <= 4'd1;
                end else begin
                    code = job.one_code + 4'd6;
                    emit = step_reg == 4'd0;
                end
            end
            cbm_pkg::JOB_REFRESH: begin
                emit = (step_reg == 4'd12) || (step_reg < 4'd4 ? job.do_prg : job.do_chr);
            end
            default: begin
                // status only: nothing before the last step
                code = 4'd12;
                emit = step_reg == 4'd12;
            end
        endcase
    end

    // Program bank placement
    always_comb begin
        pa = 16'h8000;
        pv = 8'hFF;
        unique case (code[1:0])
            2'd0: begin
                pa = sel[6] ? 16'hC000 : 16'h8000;
                pv = bk[6];
            end
            2'd1: begin
                pa = sel[6] ? 16'h8000 : 16'hC000;
                pv = 8'hFE;
            end
            2'd2: begin
                pa = 16'hA000;
                pv = bk[7];
            end
            default: begin
                pa = 16'hE000;
                pv = 8'hFF;
            end
        endcase
        if (job.op == cbm_pkg::JOB_BANKSET) begin
            pv = job.one_val;
            if (code[1:0] == 2'd0) pa = cmdo[6] ? 16'hC000 : 16'h8000;
        end
        pmask = ((8'h3F | (o1 & 8'h40) | ((o1 & 8'h20) << 2)) ^ ((o0 & 8'h40) >> 2))
                ^ ((o1 & 8'h80) >> 2);
        pbase4 = (o0 & 8'h07) | ((o1 & 8'h10) >> 1) | ((o1 & 8'h0C) << 2)
                 | ((o0 & 8'h30) << 2);
        pbase = 4'(pbase4 >> 4);
        if (o3[6] && pv >= 8'hFE && !cmdo[6] && pa[14]) pv = 8'h00;
        emask = o1[1] ? {o3[3:2], pa[14], 1'b0} : {o3[3:1], 1'b0};
        if (!o3[4]) begin
            pbank = ({pbase, pbase4[3:0], 4'h0} & ~{4'h0, pmask}) | {4'h0, pv & pmask};
        end else begin
            pbank = ({pbase, pbase4[3:0], 4'h0} & ~{4'h0, pmask & 8'hF0})
                    | {4'h0, pv & pmask & 8'hF0} | {8'h0, emask} | {11'h0, pa[13]};
        end
    end

    // Character bank placement
    always_comb begin
        cslot = code[2:0] - 3'd4;
        ca    = {cslot, 10'h000} ^ {sel[7], 12'h000};
        if (job.op == cbm_pkg::JOB_BANKSET) ca = {cslot, 10'h000} ^ {cmdo[7], 12'h000};
        unique case (cslot)
            3'd0: cv = bk[0] & 8'hFE;
            3'd1: cv = bk[0] | 8'h01;
            3'd2: cv = bk[1] & 8'hFE;
            3'd3: cv = bk[1] | 8'h01;
            3'd4: cv = bk[2];
            3'd5: cv = bk[3];
            3'd6: cv = bk[4];
            default: cv = bk[5];
        endcase
        cslot = ca[12:10];
        rel   = ca ^ {cmdo[7], 12'h000};
        cmask = 8'hFF ^ (o0 & 8'h80);
        chi   = ((o0 & 8'h08) << 4) & ~cmask;
        if (o3[4]) begin
            if (o3[6] && (rel == 13'h400 || rel == 13'hC00)) cv = cv & 8'h7F;
            cbank = (cv & 8'h80 & cmask) | chi | ({o2[3:0], 3'b000} & 8'h7F) | {5'd0, cslot};
        end else begin
            if (o3[6]) begin
                priority if (rel == 13'h000) cv = bk[0];
                else if (rel == 13'h800) cv = bk[1];
                else if (rel == 13'h400 || rel == 13'hC00) cv = 8'h00;
                else cv = cv;
            end
            cbank = (cv & cmask) | chi;
        end
    end

    always_comb begin
        priority if (code == 4'd12) begin
            kind_c = cbm_pkg::KIND_STATUS;
            slot_c = '0;
            bank_c = '0;
        end else if (code < 4'd4) begin
            kind_c = cbm_pkg::KIND_PRG;
            slot_c = {1'b0, pa[14:13]};
            bank_c = pbank;
        end else begin
            kind_c = cbm_pkg::KIND_CHR;
            slot_c = cslot;
            bank_c = {4'h0, cbank};
        end
    end

    // Output register: loads when empty or being drained
    assign is_last   = step_reg == 4'd12;
    assign fire      = job_valid && (!m_valid || m_ready);
    assign job_ready = fire && is_last;

    always_comb begin
        step_next = step_reg;
        if (fire) step_next = is_last ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            m_valid  <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (fire) m_valid <= emit;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_kind      <= kind_c;
            m_slot      <= slot_c;
            m_bank      <= bank_c;
            m_irq_line  <= is_last ? job.irq : 1'b0;
            m_mirroring <= is_last ? job.mir : 2'd0;
            m_last      <= is_last;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 4'd12)
        else $error("step out of range");
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> m_kind == cbm_pkg::KIND_STATUS)
        else $error("last beat is not status");
    a_step_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |=> step_reg == 4'd0)
        else $error("step did not wrap");
`endif
endmodule

// ===== hdl/cartridge_bank_mapper_irq.sv =====
// Top level of the cartridge bank mapper with scanline interrupt.
// Use: s_ channel carries one item (CPU write, scanline tick or mapper
// reset) per beat; m_ channel returns the program and character bank
// updates it causes, in code order, then one status beat with m_last set.
// The front part applies the item to the mapper state in the accept
// cycle and places a state snapshot in a two-entry job queue; the back
// part walks the snapshot, one step per cycle while the output is not
// stalled, over thirteen steps (four program, eight character, one
// status), emitting nothing on steps with no update. The back part's step
// walk sets the item rate; the front part accepts further items while the queue has room.
// The first result beat passes through the queue's registered read and the output register.
// four_screen is written through cfg_we/cfg_data; only while idle, a rule the block does not enforce.
// Reset: synchronous, active-low aresetn returns all mapper state to the
// power-on values and empties queue and output register.
// Stall: when m_ready is low the output register holds; the back part
// stops, the queue fills, then s_ready drops.
module cartridge_bank_mapper_irq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic [8:0]  s_scanline,
    input  logic        s_display_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_slot,
    output logic [11:0] m_bank,
    output logic        m_irq_line,
    output logic [1:0]  m_mirroring,
    output logic        m_last
);
    logic          four_screen_reg;
    logic          fq_valid, fq_ready;
    cbm_pkg::job_t fq_job;
    // two-entry queue
    logic [1:0]    q_valid_reg;
    logic          q_head_reg, q_tail_reg;
    logic          q_push, q_pop;
    logic          q_rd_addr;
    logic          q_rd_ok_reg;
    logic [cbm_pkg::JOB_W-1:0] q_rdata;
    logic          b_valid;
    logic          b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) four_screen_reg <= 1'b0;
        else if (cfg_we) four_screen_reg <= cfg_data;
    end

    cbm_front u_front (
        .aclk, .aresetn,
        .four_screen(four_screen_reg),
        .in_valid(s_valid), .in_ready(s_ready),
        .cmd(s_cmd), .address(s_address), .write_data(s_write_data),
        .scanline(s_scanline), .display_on(s_display_on),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    // Job queue
    assign fq_ready = !q_valid_reg[q_tail_reg];
    assign q_push   = fq_valid && fq_ready;
    assign q_pop    = b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= '0;
            q_head_reg  <= 1'b0;
            q_tail_reg  <= 1'b0;
        end else begin
            if (q_push) begin
                q_valid_reg[q_tail_reg] <= 1'b1;
                q_tail_reg <= !q_tail_reg;
            end
            if (q_pop) begin
                q_valid_reg[q_head_reg] <= 1'b0;
                q_head_reg <= !q_head_reg;
            end
        end
    end

    // Read the entry that is head after this edge; data is good if it was written before
    assign q_rd_addr = q_pop ? !q_head_reg : q_head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) q_rd_ok_reg <= 1'b0;
        else q_rd_ok_reg <= q_valid_reg[q_rd_addr];
    end

    cbm_ram #(
        .WIDTH(cbm_pkg::JOB_W),
        .DEPTH(2)
    ) u_queue (
        .aclk,
        .we(q_push),
        .waddr(q_tail_reg),
        .wdata(fq_job),
        .raddr(q_rd_addr),
        .rdata(q_rdata)
    );

    assign b_valid = q_valid_reg[q_head_reg] && q_rd_ok_reg;

    cbm_back u_back (
        .aclk, .aresetn,
        .job_valid(b_valid), .job_ready(b_ready),
        .job(cbm_pkg::job_t'(q_rdata)),
        .m_valid, .m_ready, .m_kind, .m_slot, .m_bank,
        .m_irq_line, .m_mirroring, .m_last
    );

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid_reg[q_head_reg])
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_valid_reg[q_tail_reg])
        else $error("push into full queue");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_bank))
        else $error("output dropped under stall");
`endif
endmodule
